### rtl/sad_pkg.sv
// ----------------------------------------------------------------------------
// Sprite attribute decoder package
// Shared widths, action and register codes, RAM word addresses and the
// request structs passed between the sequencer, the store and the adder.
// ----------------------------------------------------------------------------
`default_nettype none

package sad_pkg;

  localparam int WORD_W   = 16;
  localparam int Y_AW     = 10;
  localparam int A_AW     = 13;
  localparam int Y_WORDS  = 1024;
  localparam int A_WORDS  = 8192;
  localparam int ALU_W    = 12;
  localparam int IN_TW    = 48;
  localparam int OUT_TW   = 48;
  localparam int CFG_IW   = 2;
  localparam int CFG_DW   = 9;

  localparam logic [1:0] ACT_WR_Y    = 2'd0;
  localparam logic [1:0] ACT_WR_ATTR = 2'd1;
  localparam logic [1:0] ACT_SPRITE  = 2'd2;
  localparam logic [1:0] ACT_MAP     = 2'd3;

  localparam logic [CFG_IW-1:0] CFG_SCREEN_H  = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_VIS_MAX_Y = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_COLOR_CNT = 2'd2;

  localparam logic [Y_AW-1:0] Y_CTRL   = 10'h300;
  localparam logic [Y_AW-1:0] Y_CTRL2  = 10'h301;
  localparam logic [Y_AW-1:0] Y_XHI_LO = 10'h302;
  localparam logic [Y_AW-1:0] Y_XHI_HI = 10'h303;

  typedef struct packed {
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    logic             inv_b;
    logic             cin;
  } alu_req_t;

  typedef struct packed {
    logic              y_we;
    logic [Y_AW-1:0]   y_waddr;
    logic              a_we;
    logic [A_AW-1:0]   a_waddr;
    logic [WORD_W-1:0] wdata;
    logic [Y_AW-1:0]   y_raddr;
    logic [A_AW-1:0]   a_raddr;
  } mem_req_t;

endpackage

`default_nettype wire

### rtl/sad_alu.sv
// ----------------------------------------------------------------------------
// Shared adder
// One 12-bit add unit with optional operand inversion and carry in; serves
// every position sum and each trial subtract of the colour remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module sad_alu import sad_pkg::*; (
  input  alu_req_t         req,
  output logic [ALU_W-1:0] res
);

  logic [ALU_W-1:0] b_op;

  assign b_op = req.inv_b ? ~req.b : req.b;
  assign res  = req.a + b_op + {{(ALU_W-1){1'b0}}, req.cin};

endmodule

`default_nettype wire

### rtl/sad_store.sv
// ----------------------------------------------------------------------------
// Sprite attribute store
// Y RAM and two-bank attribute RAM, one write and one registered read port
// each, with a clearing sweep after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module sad_store import sad_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  mem_req_t          req,
  output logic [WORD_W-1:0] y_q,
  output logic [WORD_W-1:0] a_q,
  output logic              clearing
);

  logic [WORD_W-1:0] y_mem [Y_WORDS];
  logic [WORD_W-1:0] a_mem [A_WORDS];

  logic [A_AW-1:0]   clr_cnt_r;
  logic              clr_busy_r;

  logic              y_we;
  logic [Y_AW-1:0]   y_waddr;
  logic              a_we;
  logic [A_AW-1:0]   a_waddr;
  logic [WORD_W-1:0] wdata;

  assign clearing = clr_busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == A_AW'(A_WORDS - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_comb begin
    if (clr_busy_r) begin
      y_we    = 1'b1;
      y_waddr = clr_cnt_r[Y_AW-1:0];
      a_we    = 1'b1;
      a_waddr = clr_cnt_r;
      wdata   = '0;
    end else begin
      y_we    = req.y_we;
      y_waddr = req.y_waddr;
      a_we    = req.a_we;
      a_waddr = req.a_waddr;
      wdata   = req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (y_we) begin
      y_mem[y_waddr] <= wdata;
    end
    y_q <= y_mem[req.y_raddr];
  end

  always_ff @(posedge clk) begin
    if (a_we) begin
      a_mem[a_waddr] <= wdata;
    end
    a_q <= a_mem[req.a_raddr];
  end

endmodule

`default_nettype wire

### rtl/sprite_attribute_decoder_core.sv
// ----------------------------------------------------------------------------
// Sprite attribute decoder core
// RAM write items and sprite / floating-map decode items; decodes run through
// a short sequencer that reuses one 12-bit adder for position and colour sums.
// ----------------------------------------------------------------------------
// Write items leave the sequencer idle, so the block stays ready after them.
// Decodes: read states RD0, RD1 and RD2 and 11 adder steps, then the first draw
// command is loaded, then one per cycle while out_tready is high; ready returns
// after the last is loaded, or straight after RD0 when a map tile is skipped.
// Reset (rst_n low, synchronous) resets the control registers, then a sweep
// clears both RAMs; no item is taken meanwhile, config writes are.
`default_nettype none

module sprite_attribute_decoder_core import sad_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  // word_addr[12:0], write_data[28:13], sprite_index[37:29], column[41:38],
  // tile_in_column[46:42], zero[47]
  input  logic [IN_TW-1:0]  in_tdata,
  // action[1:0]
  input  logic [1:0]        in_tuser,
  output logic              out_tvalid,
  input  logic              out_tready,
  // tile_code[14:0], color_code[19:15], flip_x[20], flip_y[21],
  // pos_x[32:22], pos_y[43:33], zero[47:44]
  output logic [OUT_TW-1:0] out_tdata,
  output logic              out_tlast,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD0  = 3'd1;
  localparam logic [2:0] ST_RD1  = 3'd2;
  localparam logic [2:0] ST_RD2  = 3'd3;
  localparam logic [2:0] ST_CALC = 3'd4;
  localparam logic [2:0] ST_EMIT = 3'd5;

  localparam logic [2:0] D_NONE = 3'd0;
  localparam logic [2:0] D_T    = 3'd1;
  localparam logic [2:0] D_PX   = 3'd2;
  localparam logic [2:0] D_PY   = 3'd3;
  localparam logic [2:0] D_REM  = 3'd4;

  localparam logic [3:0] STEP_LAST = 4'd10;

  logic [2:0]        st_r;
  logic [3:0]        step_r;
  logic [1:0]        emit_idx_r;
  logic              map_r;
  logic [8:0]        sidx_r;
  logic [3:0]        col_r;
  logic [4:0]        tile_r;
  logic [8:0]        h_r;
  logic [8:0]        vmax_r;
  logic [5:0]        count_r;
  logic [WORD_W-1:0] ctrl_r;
  logic [WORD_W-1:0] ctrl2_r;
  logic [7:0]        xhi_lo_r;
  logic [7:0]        xhi_hi_r;
  logic [WORD_W-1:0] code_r;
  logic [WORD_W-1:0] cw_r;
  logic [7:0]        yv_r;
  logic [7:0]        xv_r;
  logic [ALU_W-1:0]  t_r;
  logic [ALU_W-1:0]  rem_r;
  logic [10:0]       px_r;
  logic [10:0]       py_r;
  logic              out_tvalid_r;
  logic [OUT_TW-1:0] out_tdata_r;
  logic              out_tlast_r;

  logic [12:0]       in_addr;
  logic [15:0]       in_wdata;
  logic [8:0]        in_sidx;
  logic [3:0]        in_col;
  logic [4:0]        in_tile;
  logic              accept;
  logic              clearing;
  logic              flip;
  logic              bank;
  logic [3:0]        kcol;
  logic [3:0]        kofs;
  logic              skip;
  logic [15:0]       xhi;
  logic              xhi_bit;
  logic [ALU_W-1:0]  row16;
  logic [2:0]        sh;
  mem_req_t          mreq;
  logic [WORD_W-1:0] y_q;
  logic [WORD_W-1:0] a_q;
  alu_req_t          alu_req;
  logic [ALU_W-1:0]  alu_res;
  logic [2:0]        dest;
  logic              out_load;
  logic              emit_last;
  logic [10:0]       ox;
  logic [10:0]       oy;

  assign in_addr  = in_tdata[12:0];
  assign in_wdata = in_tdata[28:13];
  assign in_sidx  = in_tdata[37:29];
  assign in_col   = in_tdata[41:38];
  assign in_tile  = in_tdata[46:42];

  assign in_tready = (st_r == ST_IDLE) && !clearing;
  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign flip    = ctrl_r[6];
  assign bank    = ctrl2_r[6] ^ ~ctrl2_r[5];
  assign kcol    = col_r + kofs;
  assign skip    = map_r && (ctrl2_r[3:0] != 4'd1) && (col_r >= ctrl2_r[3:0]);
  assign xhi     = {xhi_hi_r, xhi_lo_r};
  assign xhi_bit = xhi[col_r];
  assign row16   = {4'b0, tile_r[4:1], 4'b0};
  assign sh      = 3'(STEP_LAST - step_r);

  always_comb begin
    case (ctrl_r[3:0])
      4'd1:    kofs = 4'd4;
      4'd6:    kofs = 4'd8;
      default: kofs = 4'd0;
    endcase
  end

  // RAM requests
  always_comb begin
    mreq         = '0;
    mreq.y_we    = accept && (in_tuser == ACT_WR_Y);
    mreq.a_we    = accept && (in_tuser == ACT_WR_ATTR);
    mreq.y_waddr = in_addr[Y_AW-1:0];
    mreq.a_waddr = in_addr;
    mreq.wdata   = in_wdata;
    if (st_r == ST_RD1) begin
      mreq.y_raddr = {2'b10, col_r, 4'h4};
      mreq.a_raddr = map_r ? {bank, 3'b011, kcol, tile_r} : {bank, 3'b001, sidx_r};
    end else begin
      mreq.y_raddr = map_r ? {2'b10, col_r, 4'h0} : {1'b0, sidx_r};
      mreq.a_raddr = map_r ? {bank, 3'b010, kcol, tile_r} : {bank, 3'b000, sidx_r};
    end
  end

  sad_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (mreq),
    .y_q      (y_q),
    .a_q      (a_q),
    .clearing (clearing)
  );

  // adder step program
  always_comb begin
    alu_req = '0;
    dest    = D_NONE;
    if (st_r == ST_CALC) begin
      case (step_r) inside
        4'd0: begin
          alu_req.a     = {3'b0, h_r};
          alu_req.b     = {3'b0, vmax_r};
          alu_req.inv_b = 1'b1;
          dest          = D_T;
        end
        4'd1: begin
          if (map_r) begin
            alu_req.a = t_r;
            alu_req.b = {4'b0, yv_r};
          end else begin
            alu_req.a = flip ? t_r : {4'b0, yv_r};
            alu_req.b = flip ? {3'b0, h_r} : '0;
          end
          dest = D_T;
        end
        4'd2: begin
          alu_req.a = t_r;
          if (map_r) begin
            alu_req.b = flip ? 12'hfe9 : 12'd7;
          end else begin
            alu_req.b     = flip ? {4'b0, yv_r} : '0;
            alu_req.inv_b = 1'b1;
            alu_req.cin   = 1'b1;
          end
          dest = D_T;
        end
        4'd3: begin
          if (map_r) begin
            alu_req.a     = flip ? t_r : row16;
            alu_req.b     = flip ? row16 : t_r;
            alu_req.inv_b = 1'b1;
            alu_req.cin   = 1'b1;
            dest          = D_PY;
          end else begin
            alu_req.a = t_r;
            alu_req.b = 12'd6;
            dest      = D_T;
          end
        end
        4'd4: begin
          if (map_r) begin
            alu_req.a = {4'b0, xv_r};
            alu_req.b = {3'b0, xhi_bit, 2'b0, tile_r[0], ~tile_r[0], 4'b0};
            dest      = D_PX;
          end else begin
            alu_req.a     = {3'b0, h_r};
            alu_req.b     = {4'b0, t_r[7:0]};
            alu_req.inv_b = 1'b1;
            alu_req.cin   = 1'b1;
            dest          = D_PY;
          end
        end
        4'd5: begin
          if (!map_r) begin
            alu_req.a = {3'b0, cw_r[8:0]};
            alu_req.b = 12'd16;
            dest      = D_PX;
          end
        end
        [4'd6:4'd10]: begin
          alu_req.a     = rem_r;
          alu_req.b     = {6'b0, count_r} << sh;
          alu_req.inv_b = 1'b1;
          alu_req.cin   = 1'b1;
          dest          = D_REM;
        end
        default: begin
          dest = D_NONE;
        end
      endcase
    end
  end

  sad_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  // configuration and control shadows
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r      <= 9'd240;
      vmax_r   <= 9'd239;
      count_r  <= 6'd32;
      ctrl_r   <= '0;
      ctrl2_r  <= '0;
      xhi_lo_r <= '0;
      xhi_hi_r <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_SCREEN_H:  h_r     <= cfg_data;
          CFG_VIS_MAX_Y: vmax_r  <= cfg_data;
          CFG_COLOR_CNT: count_r <= cfg_data[5:0];
          default: ;
        endcase
      end
      if (mreq.y_we) begin
        if (mreq.y_waddr == Y_CTRL)   ctrl_r   <= in_wdata;
        if (mreq.y_waddr == Y_CTRL2)  ctrl2_r  <= in_wdata;
        if (mreq.y_waddr == Y_XHI_LO) xhi_lo_r <= in_wdata[7:0];
        if (mreq.y_waddr == Y_XHI_HI) xhi_hi_r <= in_wdata[7:0];
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      unique case (st_r)
        ST_IDLE: begin
          if (accept && (in_tuser == ACT_SPRITE || in_tuser == ACT_MAP)) begin
            st_r <= ST_RD0;
          end
        end
        ST_RD0: st_r <= skip ? ST_IDLE : ST_RD1;
        ST_RD1: st_r <= ST_RD2;
        ST_RD2: st_r <= ST_CALC;
        ST_CALC: begin
          if (step_r == STEP_LAST) begin
            st_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_load && emit_last) begin
            st_r <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      map_r  <= (in_tuser == ACT_MAP);
      sidx_r <= in_sidx;
      col_r  <= in_col;
      tile_r <= in_tile;
    end
    if (st_r == ST_RD1) begin
      code_r <= a_q;
      yv_r   <= y_q[7:0];
    end
    if (st_r == ST_RD2) begin
      cw_r   <= a_q;
      xv_r   <= y_q[7:0];
      rem_r  <= {7'b0, a_q[15:11]};
      step_r <= '0;
    end
    if (st_r == ST_CALC) begin
      step_r     <= step_r + 1'b1;
      emit_idx_r <= '0;
      unique case (dest)
        D_T:  t_r  <= alu_res;
        D_PX: px_r <= map_r ? alu_res[10:0] : {2'b0, alu_res[8:0]};
        D_PY: py_r <= alu_res[10:0];
        D_REM: begin
          if (count_r != '0 && !alu_res[ALU_W-1]) begin
            rem_r <= alu_res;
          end
        end
        default: ;
      endcase
    end
    if (out_load) begin
      emit_idx_r <= emit_idx_r + 1'b1;
    end
  end

  // draw command output register
  assign out_load  = (st_r == ST_EMIT) && (!out_tvalid_r || out_tready);
  assign emit_last = !map_r || (emit_idx_r == 2'd3);
  assign ox = emit_idx_r[0] ? {px_r[10:9] - 2'd1, px_r[8:0]} : px_r;
  assign oy = emit_idx_r[1] ? {py_r[10:8] + 3'd1, py_r[7:0]} : py_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= {4'b0, oy, ox, code_r[14] ^ flip, code_r[15] ^ flip,
                      rem_r[4:0], cw_r[9], code_r[13:0]};
      out_tlast_r <= emit_last;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  a_no_item_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !in_tready)
    else $error("item taken during RAM clear");

  a_busy_after_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_tuser == ACT_SPRITE || in_tuser == ACT_MAP)) |=> !in_tready)
    else $error("ready after decode accept");

  a_rem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_EMIT && count_r != '0) |-> (rem_r < {6'b0, count_r}))
    else $error("colour remainder not reduced");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && emit_last) |=> (st_r == ST_IDLE))
    else $error("sequencer not idle after last command");

endmodule

`default_nettype wire
